FILE: hw/rtl/sha_pkg.sv
package sha_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_t;

  typedef logic [31:0] word_t;

  localparam int unsigned BLOCK_WORDS    = 16;
  localparam int unsigned ROUNDS         = 64;
  localparam int unsigned DIGEST_WORDS   = 8;
  localparam int unsigned LEN_START_BYTE = 56;
  localparam logic [7:0]  PAD_MARK       = 8'h80;

  // Round constants
  localparam word_t ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Initial hash value
  localparam word_t INIT_H [DIGEST_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Control bundle for the block buffer / schedule window
  typedef struct packed {
    logic       wr;
    logic [7:0] data;
    logic [5:0] fill;
    logic       pad;
    logic       mark;
    logic       len_blk;
    logic       shift;
  } buf_ctl_t;

  // Control bundle for the round core
  typedef struct packed {
    logic       start;
    logic       rnd;
    logic [5:0] idx;
    logic       add;
    logic       reinit;
  } core_ctl_t;

  function automatic word_t big_s0(word_t a);
    return {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
  endfunction

  function automatic word_t big_s1(word_t e);
    return {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
  endfunction

  function automatic word_t small_s0(word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
  endfunction

  function automatic word_t small_s1(word_t y);
    return {y[16:0], y[31:17]} ^ {y[18:0], y[31:19]} ^ (y >> 10);
  endfunction

endpackage

FILE: hw/rtl/sha_msg_buf.sv
module sha_msg_buf (
  input  logic               clk,
  input  sha_pkg::buf_ctl_t  ctl_i,
  input  logic [63:0]        bit_len_i,
  output sha_pkg::word_t     w0_o
);

  sha_pkg::word_t win_r   [sha_pkg::BLOCK_WORDS];
  sha_pkg::word_t win_nxt [sha_pkg::BLOCK_WORDS];
  sha_pkg::word_t pad_w   [sha_pkg::BLOCK_WORDS];
  sha_pkg::word_t sched_w;

  // Padded block: kept bytes, end mark, zero fill, optional bit length
  always_comb begin
    for (int j = 0; j < sha_pkg::BLOCK_WORDS; j++) begin
      for (int k = 0; k < 4; k++) begin
        if (6'(4 * j + k) < ctl_i.fill) begin
          pad_w[j][31 - 8 * k -: 8] = win_r[j][31 - 8 * k -: 8];
        end else if (6'(4 * j + k) == ctl_i.fill && !ctl_i.mark) begin
          pad_w[j][31 - 8 * k -: 8] = sha_pkg::PAD_MARK;
        end else begin
          pad_w[j][31 - 8 * k -: 8] = 8'h00;
        end
      end
    end
    if (ctl_i.len_blk) begin
      pad_w[sha_pkg::BLOCK_WORDS - 2] = bit_len_i[63:32];
      pad_w[sha_pkg::BLOCK_WORDS - 1] = bit_len_i[31:0];
    end
  end

  // Next schedule word from the window taps
  assign sched_w = win_r[0] + sha_pkg::small_s0(win_r[1]) + win_r[9]
                 + sha_pkg::small_s1(win_r[14]);

  // Window update: pad load, schedule shift or byte write
  always_comb begin
    win_nxt = win_r;
    priority if (ctl_i.pad) begin
      win_nxt = pad_w;
    end else if (ctl_i.shift) begin
      for (int i = 0; i < sha_pkg::BLOCK_WORDS - 1; i++) begin
        win_nxt[i] = win_r[i + 1];
      end
      win_nxt[sha_pkg::BLOCK_WORDS - 1] = sched_w;
    end else if (ctl_i.wr) begin
      unique case (ctl_i.fill[1:0])
        2'd0: win_nxt[ctl_i.fill[5:2]][31:24] = ctl_i.data;
        2'd1: win_nxt[ctl_i.fill[5:2]][23:16] = ctl_i.data;
        2'd2: win_nxt[ctl_i.fill[5:2]][15:8]  = ctl_i.data;
        2'd3: win_nxt[ctl_i.fill[5:2]][7:0]   = ctl_i.data;
        default: win_nxt[ctl_i.fill[5:2]][7:0] = ctl_i.data;
      endcase
    end else begin
      win_nxt = win_r;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  assign w0_o = win_r[0];

endmodule

FILE: hw/rtl/sha_round_core.sv
module sha_round_core (
  input  logic               clk,
  input  logic               rst_n,
  input  sha_pkg::core_ctl_t ctl_i,
  input  sha_pkg::word_t     w_i,
  input  logic [2:0]         rd_sel_i,
  output sha_pkg::word_t     rd_word_o
);

  sha_pkg::word_t hash_r   [sha_pkg::DIGEST_WORDS];
  sha_pkg::word_t hash_nxt [sha_pkg::DIGEST_WORDS];
  sha_pkg::word_t v_r      [sha_pkg::DIGEST_WORDS];
  sha_pkg::word_t v_nxt    [sha_pkg::DIGEST_WORDS];
  sha_pkg::word_t t1;
  sha_pkg::word_t t2;

  // One compression round
  assign t1 = v_r[7] + sha_pkg::big_s1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
            + sha_pkg::ROUND_K[ctl_i.idx] + w_i;
  assign t2 = sha_pkg::big_s0(v_r[0])
            + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));

  // Working variables
  always_comb begin
    v_nxt = v_r;
    priority if (ctl_i.start) begin
      v_nxt = hash_r;
    end else if (ctl_i.rnd) begin
      v_nxt[7] = v_r[6];
      v_nxt[6] = v_r[5];
      v_nxt[5] = v_r[4];
      v_nxt[4] = v_r[3] + t1;
      v_nxt[3] = v_r[2];
      v_nxt[2] = v_r[1];
      v_nxt[1] = v_r[0];
      v_nxt[0] = t1 + t2;
    end else begin
      v_nxt = v_r;
    end
  end

  // Chaining value: feed-forward add or restart
  always_comb begin
    hash_nxt = hash_r;
    priority if (ctl_i.reinit) begin
      hash_nxt = sha_pkg::INIT_H;
    end else if (ctl_i.add) begin
      for (int i = 0; i < sha_pkg::DIGEST_WORDS; i++) begin
        hash_nxt[i] = hash_r[i] + v_r[i];
      end
    end else begin
      hash_nxt = hash_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= sha_pkg::INIT_H;
    end else begin
      hash_r <= hash_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
  end

  assign rd_word_o = hash_r[rd_sel_i];

endmodule

FILE: hw/rtl/sha256_byte_stream_digest.sv
// Byte beat, no full block or end: taken, and ready again the next cycle.
// Block fill: load, 64 rounds on the single round unit, final add.
// End of message: pad, rounds, add per pad block (one or two); 8 digest beats.
// No bytes are taken while a block is being padded, compressed or emitted.
// Synchronous active-low reset: idle, empty block, length zero, initial hash.
module sha256_byte_stream_digest (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_number,
  output logic        out_final_word
);

  sha_pkg::state_t    state_r, state_nxt;
  logic [5:0]         rnd_r, rnd_nxt;
  logic [5:0]         fill_r, fill_nxt;
  logic [60:0]        total_r, total_nxt;
  logic [2:0]         word_r, word_nxt;
  logic               fin_r, fin_nxt;
  logic               last_r, last_nxt;
  logic               mark_r, mark_nxt;
  logic               in_acc;
  logic               out_acc;
  logic               blk_full;
  logic               len_blk;
  sha_pkg::buf_ctl_t  buf_ctl;
  sha_pkg::core_ctl_t core_ctl;
  sha_pkg::word_t     w0;
  sha_pkg::word_t     rd_word;

  assign in_acc   = in_valid && (state_r == sha_pkg::ST_IDLE);
  assign out_acc  = out_valid && !out_stall;
  assign blk_full = in_byte_present && (fill_r == 6'(4 * sha_pkg::BLOCK_WORDS - 1));
  assign len_blk  = mark_r || (fill_r < 6'(sha_pkg::LEN_START_BYTE));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sha_pkg::ST_IDLE: begin
        if (in_acc) begin
          priority if (blk_full) begin
            state_nxt = sha_pkg::ST_ROUND;
          end else if (in_end_of_message) begin
            state_nxt = sha_pkg::ST_PAD;
          end else begin
            state_nxt = sha_pkg::ST_IDLE;
          end
        end
      end
      sha_pkg::ST_PAD: begin
        state_nxt = sha_pkg::ST_ROUND;
      end
      sha_pkg::ST_ROUND: begin
        if (rnd_r == 6'(sha_pkg::ROUNDS - 1)) begin
          state_nxt = sha_pkg::ST_ADD;
        end
      end
      sha_pkg::ST_ADD: begin
        priority if (last_r) begin
          state_nxt = sha_pkg::ST_EMIT;
        end else if (fin_r) begin
          state_nxt = sha_pkg::ST_PAD;
        end else begin
          state_nxt = sha_pkg::ST_IDLE;
        end
      end
      sha_pkg::ST_EMIT: begin
        if (out_acc && out_final_word) begin
          state_nxt = sha_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sha_pkg::ST_IDLE;
    endcase
  end

  // Outputs and unit control
  always_comb begin
    in_stall          = (state_r != sha_pkg::ST_IDLE);
    out_valid         = (state_r == sha_pkg::ST_EMIT);

    buf_ctl.wr        = in_acc && in_byte_present;
    buf_ctl.data      = in_data_byte;
    buf_ctl.fill      = fill_r;
    buf_ctl.pad       = (state_r == sha_pkg::ST_PAD);
    buf_ctl.mark      = mark_r;
    buf_ctl.len_blk   = len_blk;
    buf_ctl.shift     = (state_r == sha_pkg::ST_ROUND);

    core_ctl.start    = (in_acc && blk_full) || (state_r == sha_pkg::ST_PAD);
    core_ctl.rnd      = (state_r == sha_pkg::ST_ROUND);
    core_ctl.idx      = rnd_r;
    core_ctl.add      = (state_r == sha_pkg::ST_ADD);
    core_ctl.reinit   = out_acc && out_final_word;
  end

  // Counters and message flags
  always_comb begin
    rnd_nxt   = (state_r == sha_pkg::ST_ROUND) ? rnd_r + 6'd1 : 6'd0;
    fill_nxt  = fill_r;
    total_nxt = total_r;
    word_nxt  = word_r;
    fin_nxt   = fin_r;
    last_nxt  = last_r;
    mark_nxt  = mark_r;
    if (in_acc) begin
      if (in_byte_present) begin
        fill_nxt  = fill_r + 6'd1;
        total_nxt = total_r + 61'd1;
      end
      if (in_end_of_message) begin
        fin_nxt = 1'b1;
      end
    end
    if (state_r == sha_pkg::ST_PAD) begin
      fill_nxt = 6'd0;
      if (len_blk) begin
        last_nxt = 1'b1;
      end else begin
        mark_nxt = 1'b1;
      end
    end
    if (out_acc) begin
      word_nxt = word_r + 3'd1;
      if (out_final_word) begin
        fill_nxt  = 6'd0;
        total_nxt = '0;
        fin_nxt   = 1'b0;
        last_nxt  = 1'b0;
        mark_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha_pkg::ST_IDLE;
      rnd_r   <= '0;
      fill_r  <= '0;
      total_r <= '0;
      word_r  <= '0;
      fin_r   <= 1'b0;
      last_r  <= 1'b0;
      mark_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
      fill_r  <= fill_nxt;
      total_r <= total_nxt;
      word_r  <= word_nxt;
      fin_r   <= fin_nxt;
      last_r  <= last_nxt;
      mark_r  <= mark_nxt;
    end
  end

  sha_msg_buf u_buf (
    .clk       (clk),
    .ctl_i     (buf_ctl),
    .bit_len_i ({total_r, 3'b000}),
    .w0_o      (w0)
  );

  sha_round_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_i     (core_ctl),
    .w_i       (w0),
    .rd_sel_i  (word_r),
    .rd_word_o (rd_word)
  );

  // Digest beats straight from the chaining registers
  assign out_digest_word = rd_word;
  assign out_word_number = word_r;
  assign out_final_word  = (word_r == 3'(sha_pkg::DIGEST_WORDS - 1));

  // Final digest beat leaves the block empty and idle
  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_final_word) |=> (state_r == sha_pkg::ST_IDLE && fill_r == 6'd0
                                     && total_r == '0))
    else $error("block not cleared after final digest beat");

  // Feed-forward add only after the last round
  a_add_after_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha_pkg::ST_ADD) |-> ($past(state_r) == sha_pkg::ST_ROUND
                                      && $past(rnd_r) == 6'(sha_pkg::ROUNDS - 1)))
    else $error("hash add without a full round sequence");

  // Pad load always starts a fresh round sequence
  a_pad_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha_pkg::ST_PAD) |=> (state_r == sha_pkg::ST_ROUND && rnd_r == 6'd0))
    else $error("pad block not followed by round zero");

  // Digest beats come in order without a gap in numbering
  a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && !out_final_word) |=> (out_valid
                                      && out_word_number == 3'($past(out_word_number) + 1)))
    else $error("digest word numbering out of order");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 200;

  // SHA-256 round constants
  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Starting hash value
  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct {
    logic [31:0] word;
    logic [2:0]  number;
    logic        last;
  } digest_beat_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_byte_present;
  logic        in_end_of_message;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_number;
  logic        out_final_word;

  // Digest predictor state
  logic [31:0] hash_h [8];
  logic [7:0]  msg_block [64];
  int unsigned fill_bytes;
  logic [60:0] total_bytes;

  digest_beat_t digest_queue [$];
  int unsigned  error_count;
  int unsigned  cycle_count;
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;
  int unsigned  hold_req;

  sha256_byte_stream_digest uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_byte_present   (in_byte_present),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_digest_word   (out_digest_word),
    .out_word_number   (out_word_number),
    .out_final_word    (out_final_word)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic clear_digest_state();
    int i;
    for (i = 0; i < 8; i++) hash_h[i] = SHA_IV[i];
    fill_bytes  = 0;
    total_bytes = '0;
  endtask

  // One 64-round compression of msg_block into hash_h
  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    int i;
    for (i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    a = hash_h[0]; b = hash_h[1]; c = hash_h[2]; d = hash_h[3];
    e = hash_h[4]; f = hash_h[5]; g = hash_h[6]; h = hash_h[7];
    for (i = 0; i < 64; i++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
           + SHA_K[i] + w[i];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_h[0] += a; hash_h[1] += b; hash_h[2] += c; hash_h[3] += d;
    hash_h[4] += e; hash_h[5] += f; hash_h[6] += g; hash_h[7] += h;
  endtask

  // Pad, append the bit length, compress and queue the eight digest beats
  task automatic finish_message();
    logic [63:0]  bit_len;
    digest_beat_t beat;
    int n, i;
    bit_len = {total_bytes, 3'b000};
    n = fill_bytes;
    msg_block[n] = 8'h80;
    n = n + 1;
    if (n > 56) begin
      while (n < 64) begin
        msg_block[n] = 8'h00;
        n = n + 1;
      end
      compress_block();
      n = 0;
    end
    while (n < 56) begin
      msg_block[n] = 8'h00;
      n = n + 1;
    end
    for (i = 0; i < 8; i++) msg_block[63-i] = bit_len[8*i +: 8];
    compress_block();
    for (i = 0; i < 8; i++) begin
      beat.word   = hash_h[i];
      beat.number = 3'(i);
      beat.last   = (i == 7);
      digest_queue.push_back(beat);
    end
    clear_digest_state();
  endtask

  task automatic predict_item(input logic [7:0] data, input logic has_byte,
                              input logic ends);
    if (has_byte) begin
      msg_block[fill_bytes] = data;
      fill_bytes  = fill_bytes + 1;
      total_bytes = total_bytes + 61'd1;
      if (fill_bytes == 64) begin
        compress_block();
        fill_bytes = 0;
      end
    end
    if (ends) finish_message();
  endtask

  // Offer one beat on the input, with random idle cycles ahead of it
  task automatic send_item(input logic [7:0] data, input logic has_byte,
                           input logic ends);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid          = 1'b1;
    in_data_byte      = data;
    in_byte_present   = has_byte;
    in_end_of_message = ends;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(data, has_byte, ends);
    @(negedge clk);
  endtask

  // Message of random bytes with stray empty beats; returns beats that count
  task automatic send_message(input int unsigned len, input bit empty_end,
                              output int unsigned counted);
    int unsigned k;
    counted = 0;
    for (k = 0; k < len; k++) begin
      if ($urandom_range(9) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(255)), 1'b1, (k == len - 1) && !empty_end);
      counted++;
    end
    if (empty_end || len == 0) begin
      send_item(8'($urandom_range(255)), 1'b0, 1'b1);
      counted++;
    end
  endtask

  // Receiver: long hold-off on request, otherwise random stalls
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Compare each digest beat with the oldest prediction
  always @(posedge clk) begin : check_beats
    digest_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (digest_queue.size() == 0) begin
        error_count++;
        $display("%0t: unexpected beat: expected none, got word %h number %0d last %b",
                 $time, out_digest_word, out_word_number, out_final_word);
      end else begin
        want = digest_queue.pop_front();
        if (out_digest_word !== want.word) begin
          error_count++;
          $display("%0t: digest word %0d: expected %h, got %h",
                   $time, want.number, want.word, out_digest_word);
        end
        if (out_word_number !== want.number) begin
          error_count++;
          $display("%0t: word number: expected %0d, got %0d",
                   $time, want.number, out_word_number);
        end
        if (out_final_word !== want.last) begin
          error_count++;
          $display("%0t: last-word flag on word %0d: expected %b, got %b",
                   $time, want.number, want.last, out_final_word);
        end
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Special items: empty beats, empty message, byte with end, empty end beat
  task automatic test_special_items();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_item(8'ha5, 1'b0, 1'b0);
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h5a, 1'b0, 1'b1);
    send_item("a", 1'b1, 1'b0);
    send_item("b", 1'b1, 1'b0);
    send_item(8'h3c, 1'b0, 1'b0);
    send_item("c", 1'b1, 1'b1);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h7f, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h01, 1'b1, 1'b1);
    send_item(8'hc3, 1'b0, 1'b1);
  endtask

  // Random messages, weighted towards the padding boundaries
  task automatic test_random_messages(input int unsigned s_pct, input int unsigned r_pct,
                                      input int unsigned target);
    int unsigned sent, len, counted, pick;
    int unsigned edges [12] = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent = 0;
    while (sent < target) begin
      pick = $urandom_range(99);
      if (pick < 20)      len = edges[$urandom_range(11)];
      else if (pick < 85) len = $urandom_range(40);
      else                len = $urandom_range(140, 41);
      send_message(len, ($urandom_range(3) == 0), counted);
      sent += counted;
    end
  endtask

  // Long receiver hold-off while the sender keeps offering bytes
  task automatic test_output_hold();
    int unsigned counted;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 600;
    send_message(12, 1'b0, counted);
    send_message(40, 1'b0, counted);
    send_message(3, 1'b1, counted);
  endtask

  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_data_byte      = 8'h00;
    in_byte_present   = 1'b0;
    in_end_of_message = 1'b0;
    error_count       = 0;
    hold_req          = 0;
    send_idle_pct     = 0;
    recv_idle_pct     = 0;
    clear_digest_state();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_special_items();
    test_random_messages(24, 50, 50);
    test_random_messages(50, 24, 50);
    test_random_messages(0, 0, 50);
    test_output_hold();
    in_valid = 1'b0;

    // Drain, then give the block time to show any stray beats
    while (digest_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/sha_pkg.sv
hw/rtl/sha_msg_buf.sv
hw/rtl/sha_round_core.sv
hw/rtl/sha256_byte_stream_digest.sv
test/testbench.sv
